### rtl/chacha20_stream_cipher_unit_macros.svh
// Assertion helpers shared by the cipher unit's RTL.
// Each macro expects clk and rst_n in scope.
`ifndef CHACHA20_STREAM_CIPHER_UNIT_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_UNIT_MACROS_SVH

// Expression holds at every clock edge outside reset
`define CCSU_ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle
`define CCSU_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define CCSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ccsu_pkg.sv
`default_nettype none

package ccsu_pkg;

    // ChaCha20 constants ("expand 32-byte k")
    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int ROUNDS        = 2 * DOUBLE_ROUNDS;
    localparam int RND_W         = $clog2(ROUNDS + 1);

    localparam int ROT_A = 16;
    localparam int ROT_B = 12;
    localparam int ROT_C = 8;
    localparam int ROT_D = 7;

    // Default queue depths
    localparam int CCSU_WORK_DEPTH = 4;
    localparam int CCSU_OUT_DEPTH  = 2;

    typedef logic [31:0]       word_t;
    typedef logic [15:0][31:0] state_t;
    typedef logic [7:0][63:0]  keystream_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_KEY_WORD_0    = 3'd0,
        REG_KEY_WORD_1    = 3'd1,
        REG_KEY_WORD_2    = 3'd2,
        REG_KEY_WORD_3    = 3'd3,
        REG_NONCE_LOW     = 3'd4,
        REG_NONCE_HIGH    = 3'd5,
        REG_START_COUNTER = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [63:0] key_word_0;
        logic [63:0] key_word_1;
        logic [63:0] key_word_2;
        logic [63:0] key_word_3;
        logic [63:0] nonce_low;
        logic [31:0] nonce_high;
        logic [31:0] start_counter;
    } cfg_t;

    typedef struct packed {
        logic [63:0] in_data;
        logic [3:0]  in_count;
        logic        in_last;
    } in_item_t;

    typedef struct packed {
        logic [63:0] out_data;
        logic [3:0]  out_count;
        logic        out_last;
    } out_item_t;

    // Work entry handed from the front end to the back end
    typedef struct packed {
        in_item_t    item;
        logic [2:0]  word_idx;
        logic [31:0] counter;
    } work_t;

    localparam int WORK_W = $bits(work_t);
    localparam int OUT_W  = $bits(out_item_t);

    function automatic word_t rotl(input word_t x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    // One quarter round; result index 0..3 = a, b, c, d
    function automatic logic [3:0][31:0] quarter_round(input word_t a, input word_t b,
                                                        input word_t c, input word_t d);
        word_t ta;
        word_t tb;
        word_t tc;
        word_t td;
        ta = a + b; td = rotl(d ^ ta, ROT_A);
        tc = c + td; tb = rotl(b ^ tc, ROT_B);
        ta = ta + tb; td = rotl(td ^ ta, ROT_C);
        tc = tc + td; tb = rotl(tb ^ tc, ROT_D);
        quarter_round = {td, tc, tb, ta};
    endfunction

    // Column round (diag low) or diagonal round (diag high)
    function automatic state_t chacha_round(input state_t s, input logic diag);
        state_t          r;
        logic [3:0][31:0] q;
        logic [3:0]      ia;
        logic [3:0]      ib;
        logic [3:0]      ic;
        logic [3:0]      id;
        r = s;
        for (int i = 0; i < 4; i++) begin
            ia = 4'(i);
            ib = diag ? 4'(4 + ((i + 1) & 3))  : 4'(4 + i);
            ic = diag ? 4'(8 + ((i + 2) & 3))  : 4'(8 + i);
            id = diag ? 4'(12 + ((i + 3) & 3)) : 4'(12 + i);
            q = quarter_round(s[ia], s[ib], s[ic], s[id]);
            r[ia] = q[0];
            r[ib] = q[1];
            r[ic] = q[2];
            r[id] = q[3];
        end
        chacha_round = r;
    endfunction

    // Initial block state from configuration and block counter
    function automatic state_t block_init(input cfg_t cfg, input word_t ctr);
        state_t s;
        s[0]  = SIGMA_0;
        s[1]  = SIGMA_1;
        s[2]  = SIGMA_2;
        s[3]  = SIGMA_3;
        s[4]  = cfg.key_word_0[31:0];
        s[5]  = cfg.key_word_0[63:32];
        s[6]  = cfg.key_word_1[31:0];
        s[7]  = cfg.key_word_1[63:32];
        s[8]  = cfg.key_word_2[31:0];
        s[9]  = cfg.key_word_2[63:32];
        s[10] = cfg.key_word_3[31:0];
        s[11] = cfg.key_word_3[63:32];
        s[12] = ctr;
        s[13] = cfg.nonce_low[31:0];
        s[14] = cfg.nonce_low[63:32];
        s[15] = cfg.nonce_high;
        block_init = s;
    endfunction

    // Byte mask for a valid-byte count; counts of eight and up keep all bytes
    function automatic logic [63:0] count_mask(input logic [3:0] count);
        logic [63:0] m;
        for (int b = 0; b < 8; b++) begin
            m[8*b +: 8] = (4'(b) < count) ? 8'hFF : 8'h00;
        end
        count_mask = m;
    endfunction

endpackage

`default_nettype wire

### rtl/ccsu_fifo.sv
`default_nettype none

`include "chacha20_stream_cipher_unit_macros.svh"

module ccsu_fifo
    import ccsu_pkg::*;
#(
    parameter int WIDTH = WORK_W,
    parameter int DEPTH = CCSU_WORK_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    `CCSU_ASSERT_HOLDS(a_fifo_count_bound, count_reg <= CNT_W'(DEPTH), "fifo overfilled")

endmodule

`default_nettype wire

### rtl/ccsu_front.sv
`default_nettype none

module ccsu_front
    import ccsu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire in_item_t    in_item,
    input  wire logic [31:0] start_counter,
    input  wire logic        work_full,
    output logic             work_push,
    output work_t            work_item
);

    logic [31:0] block_counter_reg;
    logic [31:0] block_counter_next;
    logic [2:0]  word_pos_reg;
    logic [2:0]  word_pos_next;
    logic        in_message_reg;
    logic        in_message_next;
    logic        accept;
    logic [2:0]  cur_pos;
    logic [31:0] cur_counter;

    assign accept = push && !work_full;

    // Classify the transaction: which keystream word, which block counter
    always_comb
    begin
        cur_pos     = in_message_reg ? word_pos_reg : 3'd0;
        cur_counter = in_message_reg ? block_counter_reg : start_counter;

        work_item.item     = in_item;
        work_item.word_idx = cur_pos;
        work_item.counter  = cur_counter;
        work_push          = accept;

        block_counter_next = block_counter_reg;
        word_pos_next      = word_pos_reg;
        in_message_next    = in_message_reg;
        if (accept)
        begin
            block_counter_next = (cur_pos == 3'd0) ? cur_counter + 32'd1 : cur_counter;
            word_pos_next      = cur_pos + 3'd1;
            in_message_next    = !in_item.in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_counter_reg <= '0;
            word_pos_reg      <= '0;
            in_message_reg    <= 1'b0;
        end
        else
        begin
            block_counter_reg <= block_counter_next;
            word_pos_reg      <= word_pos_next;
            in_message_reg    <= in_message_next;
        end
    end

endmodule

`default_nettype wire

### rtl/ccsu_core.sv
`default_nettype none

module ccsu_core
    import ccsu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire cfg_t        cfg,
    input  wire logic [31:0] counter,
    output logic             done,
    output keystream_t       keystream
);

    logic             busy_reg;
    logic [RND_W-1:0] rnd_reg;
    logic [31:0]      ctr_reg;
    state_t           w_reg;
    state_t           init_words;
    state_t           final_words;
    logic             last_step;

    assign last_step  = (rnd_reg == RND_W'(ROUNDS));
    assign done       = busy_reg && last_step;
    assign init_words = block_init(cfg, ctr_reg);

    // Feed-forward add of the initial state
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            final_words[i] = w_reg[i] + init_words[i];
        end
    end

    // Keystream word j is state words 2j and 2j+1
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            keystream[j] = {w_reg[4'(2 * j + 1)], w_reg[4'(2 * j)]};
        end
    end

    // Round sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            rnd_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (last_step)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                rnd_reg <= rnd_reg + 1'b1;
            end
        end
    end

    // Working state: load, one round per cycle, then final add
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            w_reg   <= block_init(cfg, counter);
            ctr_reg <= counter;
        end
        else if (busy_reg)
        begin
            if (last_step)
            begin
                w_reg <= final_words;
            end
            else
            begin
                w_reg <= chacha_round(w_reg, rnd_reg[0]);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/ccsu_back.sv
`default_nettype none

`include "chacha20_stream_cipher_unit_macros.svh"

module ccsu_back
    import ccsu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire work_t work_head,
    input  wire logic  work_empty,
    output logic       work_pop,
    input  wire logic  out_full,
    output logic       out_push,
    output out_item_t  out_item
);

    typedef enum logic [2:0] {
        BK_RUN  = 3'b001,
        BK_GEN  = 3'b010,
        BK_EMIT = 3'b100
    } back_state_t;

    back_state_t state_reg;
    back_state_t state_next;
    logic        head_needs_block;
    logic        emit;
    logic        core_start;
    logic        core_done;
    keystream_t  keystream;
    logic [63:0] ks_word;

    assign head_needs_block = (work_head.word_idx == 3'd0);

    assign core_start = (state_reg == BK_RUN) && !work_empty && head_needs_block;
    assign emit       = !out_full && !work_empty &&
                        (((state_reg == BK_RUN) && !head_needs_block) ||
                         (state_reg == BK_EMIT));

    assign work_pop = emit;
    assign out_push = emit;

    // Keystream block generator
    ccsu_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (core_start),
        .cfg       (cfg),
        .counter   (work_head.counter),
        .done      (core_done),
        .keystream (keystream)
    );

    // Result formation
    always_comb
    begin
        ks_word            = keystream[work_head.word_idx];
        out_item.out_data  = (work_head.item.in_data ^ ks_word) &
                             count_mask(work_head.item.in_count);
        out_item.out_count = work_head.item.in_count;
        out_item.out_last  = work_head.item.in_last;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_RUN:
            begin
                if (core_start)
                begin
                    state_next = BK_GEN;
                end
            end
            BK_GEN:
            begin
                if (core_done)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (emit)
                begin
                    state_next = BK_RUN;
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `CCSU_ASSERT_IMPLIES(a_gen_holds_head, state_reg != BK_RUN, !work_empty,
        "work entry lost during block generation")
    `CCSU_ASSERT_IMPLIES(a_done_in_gen, core_done, state_reg == BK_GEN,
        "core finished outside generation")
    `CCSU_ASSERT_NEXT(a_emit_after_done, core_done, state_reg == BK_EMIT && head_needs_block,
        "block not followed by its first word")

endmodule

`default_nettype wire

### rtl/chacha20_stream_cipher_unit.sv
// ChaCha20 (RFC 8439, 20 rounds) stream cipher unit. Write key, nonce and
// start counter through the cfg port while the unit is idle, then push
// 8-byte transactions; each result is the data XOR keystream with bytes past
// the count zeroed, and in_last closes a message so the next one restarts at
// the start counter. A front end assigns each transaction its keystream word
// and block counter and queues it; the back end generates a 64-byte block
// with one ChaCha round per cycle (start, 20 rounds, then the feed-forward
// add) whenever a transaction needs word 0, and otherwise emits one result
// per cycle while the result queue has room. Sustained throughput is set by
// the round unit; input and output queues let both sides stall
// independently.
`default_nettype none

module chacha20_stream_cipher_unit
    import ccsu_pkg::*;
#(
    parameter int WORK_DEPTH = CCSU_WORK_DEPTH,
    parameter int OUT_DEPTH  = CCSU_OUT_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        push,
    input  wire in_item_t    in_item,
    output logic             full,
    input  wire logic        pop,
    output out_item_t        out_item,
    output logic             empty
);

    cfg_t             cfg_reg;
    logic             work_push;
    work_t            work_item;
    logic             work_full;
    logic             work_pop;
    logic [WORK_W-1:0] work_rdata;
    work_t            work_head;
    logic             work_empty;
    logic             out_push;
    out_item_t        out_wdata;
    logic             out_full;
    logic [OUT_W-1:0] out_rdata;

    assign full      = work_full;
    assign work_head = work_t'(work_rdata);
    assign out_item  = out_item_t'(out_rdata);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_KEY_WORD_0:    cfg_reg.key_word_0    <= cfg_wdata;
                REG_KEY_WORD_1:    cfg_reg.key_word_1    <= cfg_wdata;
                REG_KEY_WORD_2:    cfg_reg.key_word_2    <= cfg_wdata;
                REG_KEY_WORD_3:    cfg_reg.key_word_3    <= cfg_wdata;
                REG_NONCE_LOW:     cfg_reg.nonce_low     <= cfg_wdata;
                REG_NONCE_HIGH:    cfg_reg.nonce_high    <= cfg_wdata[31:0];
                REG_START_COUNTER: cfg_reg.start_counter <= cfg_wdata[31:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front end: message tracking and keystream word assignment
    ccsu_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .in_item       (in_item),
        .start_counter (cfg_reg.start_counter),
        .work_full     (work_full),
        .work_push     (work_push),
        .work_item     (work_item)
    );

    // Queue between front and back
    ccsu_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (WORK_DEPTH)
    ) u_work_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (work_push),
        .wdata (work_item),
        .full  (work_full),
        .pop   (work_pop),
        .rdata (work_rdata),
        .empty (work_empty)
    );

    // Back end: block generation and XOR
    ccsu_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .work_head  (work_head),
        .work_empty (work_empty),
        .work_pop   (work_pop),
        .out_full   (out_full),
        .out_push   (out_push),
        .out_item   (out_wdata)
    );

    // Result queue
    ccsu_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wdata),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

endmodule

`default_nettype wire
